@@ rtl/wsdm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wsdm_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_FOCUS  = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_FOCUS = 2'd1;
    localparam logic [1:0] KIND_MOVE  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic signed [17:0] TITLE_H   = 18'sd20;
    localparam logic signed [17:0] CLOSE_OFF = 18'sd18;
    localparam logic signed [17:0] CLOSE_IN  = 18'sd2;
    localparam logic [15:0]        ID_FIRST  = 16'd1;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [14:0] w;
        logic [14:0] h;
        logic [15:0] id;
        logic        drag;
        logic [15:0] ax;
        logic [15:0] ay;
    } entry_t;

    typedef struct packed {
        logic wr;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FOCUS,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/wsdm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsdm_cell (
    input  wire                 aclk,
    input  wsdm_pkg::cell_ctl_t ctl,
    input  wsdm_pkg::entry_t    up_entry,
    input  wsdm_pkg::entry_t    wr_entry,
    output wsdm_pkg::entry_t    entry
);
    import wsdm_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            entry_reg <= wr_entry;
        end else if (ctl.shift) begin
            entry_reg <= up_entry;
        end
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

@@ rtl/window_stack_drag_manager_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | tdata                                          | tuser | tlast
// s_       | in        | win_x win_y win_width win_height ptr_x ptr_y   | cmd   | -
//          |           | pressed released                               |       |
// m_       | out       | window_id dirty_x dirty_y dirty_w dirty_h      | kind  | last
//          |           | flag closed                                    |       |
// add: writes the new window on top; focus: walks down the stack from the top cell
// update: walks up from the bottom, one cell visited per cycle (at most one result a step)
// a request is taken only in idle; a stalled result holds the walk
// synchronous active-low reset clears count and handshake state and sets next id to ID_FIRST
module window_stack_drag_manager_core #(
    parameter int MAX_WIN = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // win_x, win_y, win_width, win_height, pointer_x,
                                   // pointer_y, pressed, released
    input  wire  [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,   // window_id, dirty_x, dirty_y, dirty_w, dirty_h,
                                   // flag, closed, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);
    import wsdm_pkg::*;

    localparam int CW = $clog2(MAX_WIN + 1);
    localparam int IW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;

    state_t state_reg, state_next;
    logic [1:0]  cmd_reg;
    logic [95:0] req_reg;
    logic [CW-1:0] count_reg, count_next, idx_reg, idx_next;
    logic [15:0] nid_reg, nid_next;
    logic changed_reg, changed_next;

    logic        mv_reg;
    logic [1:0]  mk_reg;
    logic [87:0] md_reg;
    logic        ml_reg;

    entry_t cell_q [MAX_WIN];
    cell_ctl_t cell_c [MAX_WIN];
    entry_t sel, wr_entry, ne, add_e;

    logic out_free;
    logic emit, to_idle, to_focus, to_upd, to_done;
    logic wr_en, rot_en, rm_en;
    logic [IW-1:0] wr_idx;
    logic [1:0]  o_kind;
    logic [15:0] o_id, o_dx, o_dy, o_dw, o_dh;
    logic o_flag, o_closed, o_last;

    logic [15:0] r_px, r_py;
    logic r_pr, r_rl;
    logic signed [17:0] xs, ys, ws, hs, pxs, pys, right, bottom;
    logic top, in_close, in_title, hit, chg, moved;
    logic [15:0] mx, my;
    logic signed [18:0] oxs, oys, nxs, nys, dxs, dys, rr, bb, dwf, dhf;

    genvar g;
    generate
        for (g = 0; g < MAX_WIN; g++) begin : g_cell
            if (g == MAX_WIN - 1) begin : g_top
                wsdm_cell u_cell (
                    .aclk(aclk), .ctl(cell_c[g]), .up_entry(cell_q[g]),
                    .wr_entry(wr_entry), .entry(cell_q[g])
                );
            end else begin : g_mid
                wsdm_cell u_cell (
                    .aclk(aclk), .ctl(cell_c[g]), .up_entry(cell_q[g+1]),
                    .wr_entry(wr_entry), .entry(cell_q[g])
                );
            end
        end
    endgenerate

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tuser  = mk_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    assign r_px = req_reg[77:62];
    assign r_py = req_reg[93:78];
    assign r_pr = req_reg[94];
    assign r_rl = req_reg[95];
    assign sel  = cell_q[idx_reg[IW-1:0]];

    always_comb begin
        add_e = '0;
        add_e.px = req_reg[15:0];
        add_e.py = req_reg[31:16];
        add_e.w  = req_reg[46:32];
        add_e.h  = req_reg[61:47];
        add_e.id = nid_reg;
    end

    // hit tests and per-cell drag step
    always_comb begin
        xs = {{2{sel.px[15]}}, sel.px};
        ys = {{2{sel.py[15]}}, sel.py};
        ws = $signed({3'b000, sel.w});
        hs = $signed({3'b000, sel.h});
        pxs = {{2{r_px[15]}}, r_px};
        pys = {{2{r_py[15]}}, r_py};
        right = xs + ws;
        bottom = ys + hs;
        top = ((idx_reg + CW'(1)) == count_reg);
        hit = (pxs >= xs) && (pxs < right) && (pys >= ys) && (pys < bottom);
        in_close = r_pr && top && (pxs >= right - CLOSE_OFF) && (pxs < right - CLOSE_IN)
                   && (pys >= ys + CLOSE_IN) && (pys < ys + CLOSE_OFF);
        in_title = r_pr && top && (pxs >= xs) && (pxs < right)
                   && (pys >= ys) && (pys < ys + TITLE_H);
        ne = sel;
        chg = 1'b0;
        if (in_title) begin
            if (!sel.drag) chg = 1'b1;
            ne.ax = r_px;
            ne.ay = r_py;
            ne.drag = 1'b1;
        end
        if (r_rl && ne.drag) begin
            ne.drag = 1'b0;
            chg = 1'b1;
        end
        mx = r_px - ne.ax;
        my = r_py - ne.ay;
        moved = ne.drag && ((mx != 16'd0) || (my != 16'd0));
        if (moved) begin
            ne.px = sel.px + mx;
            ne.py = sel.py + my;
            ne.ax = r_px;
            ne.ay = r_py;
        end
        oxs = {{3{sel.px[15]}}, sel.px};
        oys = {{3{sel.py[15]}}, sel.py};
        nxs = {{3{ne.px[15]}}, ne.px};
        nys = {{3{ne.py[15]}}, ne.py};
        dxs = (oxs < nxs) ? oxs : nxs;
        dys = (oys < nys) ? oys : nys;
        rr = ((oxs > nxs) ? oxs : nxs) + $signed({4'b0000, sel.w});
        bb = ((oys > nys) ? oys : nys) + $signed({4'b0000, sel.h});
        dwf = rr - dxs;
        dhf = bb - dys;
    end

    // sequencer actions
    always_comb begin
        emit = 1'b0; to_idle = 1'b0; to_focus = 1'b0; to_upd = 1'b0; to_done = 1'b0;
        wr_en = 1'b0; rot_en = 1'b0; rm_en = 1'b0;
        wr_idx = idx_reg[IW-1:0];
        wr_entry = ne;
        o_kind = KIND_DONE; o_id = '0; o_dx = '0; o_dy = '0; o_dw = '0; o_dh = '0;
        o_flag = 1'b0; o_closed = 1'b0; o_last = 1'b1;
        count_next = count_reg; nid_next = nid_reg;
        idx_next = idx_reg; changed_next = changed_reg;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_DISPATCH: begin
                if (out_free) begin
                    unique case (cmd_reg)
                        CMD_ADD: begin
                            emit = 1'b1;
                            to_idle = 1'b1;
                            o_kind = KIND_ADD;
                            if (count_reg < CW'(MAX_WIN)) begin
                                wr_en = 1'b1;
                                wr_idx = count_reg[IW-1:0];
                                wr_entry = add_e;
                                count_next = count_reg + CW'(1);
                                nid_next = (nid_reg == 16'hFFFF) ? ID_FIRST : nid_reg + 16'd1;
                                o_id = nid_reg;
                                o_dx = add_e.px;
                                o_dy = add_e.py;
                                o_dw = {1'b0, add_e.w};
                                o_dh = {1'b0, add_e.h};
                            end
                        end
                        CMD_FOCUS: begin
                            if (count_reg == '0) begin
                                emit = 1'b1;
                                o_kind = KIND_FOCUS;
                                to_idle = 1'b1;
                            end else begin
                                idx_next = count_reg - CW'(1);
                                to_focus = 1'b1;
                            end
                        end
                        CMD_UPDATE: begin
                            changed_next = 1'b0;
                            idx_next = '0;
                            if (count_reg == '0) to_done = 1'b1;
                            else to_upd = 1'b1;
                        end
                        default: to_idle = 1'b1;
                    endcase
                end
            end
            ST_FOCUS: begin
                if (out_free) begin
                    if (hit) begin
                        rot_en = 1'b1;
                        wr_en = 1'b1;
                        wr_idx = count_reg[IW-1:0] - IW'(1);
                        wr_entry = sel;
                        emit = 1'b1;
                        o_kind = KIND_FOCUS;
                        o_id = sel.id;
                        o_flag = 1'b1;
                        to_idle = 1'b1;
                    end else if (idx_reg == '0) begin
                        emit = 1'b1;
                        o_kind = KIND_FOCUS;
                        to_idle = 1'b1;
                    end else begin
                        idx_next = idx_reg - CW'(1);
                    end
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    if (in_close) begin
                        rm_en = 1'b1;
                        count_next = count_reg - CW'(1);
                        emit = 1'b1;
                        o_kind = KIND_DONE;
                        o_id = sel.id;
                        o_flag = 1'b1;
                        o_closed = 1'b1;
                        to_idle = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                        if (chg || moved) changed_next = 1'b1;
                        if (moved) begin
                            emit = 1'b1;
                            o_kind = KIND_MOVE;
                            o_id = sel.id;
                            o_dx = dxs[15:0];
                            o_dy = dys[15:0];
                            o_dw = (dwf > 19'sd65535) ? 16'hFFFF : dwf[15:0];
                            o_dh = (dhf > 19'sd65535) ? 16'hFFFF : dhf[15:0];
                            o_last = 1'b0;
                        end
                        idx_next = idx_reg + CW'(1);
                        if (top) to_done = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit = 1'b1;
                    o_flag = changed_reg;
                    to_idle = 1'b1;
                end
            end
            default: to_idle = 1'b1;
        endcase
    end

    always_comb begin
        for (int j = 0; j < MAX_WIN; j++) begin
            cell_c[j].wr = wr_en && (wr_idx == IW'(j));
            cell_c[j].shift = (rot_en && ((CW+1)'(j) >= {1'b0, idx_reg})
                               && (((CW+1)'(j) + (CW+1)'(1)) < {1'b0, count_reg}))
                              || (rm_en && ((CW+1)'(j) >= {1'b0, idx_reg}));
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_DISPATCH;
            default: begin
                if (to_idle) state_next = ST_IDLE;
                else if (to_focus) state_next = ST_FOCUS;
                else if (to_upd) state_next = ST_UPD;
                else if (to_done) state_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            nid_reg <= ID_FIRST;
            mv_reg <= 1'b0;
            idx_reg <= '0;
            changed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            nid_reg <= nid_next;
            idx_reg <= idx_next;
            changed_reg <= changed_next;
            if (emit) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= s_tdata;
            cmd_reg <= s_tuser;
        end
        if (emit) begin
            mk_reg <= o_kind;
            ml_reg <= o_last;
            md_reg <= {6'b000000, o_closed, o_flag, o_dh, o_dw, o_dy, o_dx, o_id};
        end
    end

endmodule
`default_nettype wire
